// ===== rtl/csrdt_pkg.sv =====
// ----------------------------------------------------------------------------
// csrdt_pkg
// Shared types and constants for the sparse-times-dense-transpose engine.
// ----------------------------------------------------------------------------
package csrdt_pkg;

  localparam int VAL_W    = 32;
  localparam int SUM_W    = 64;
  localparam int ROW_W    = 32;
  localparam int DROW_W   = 4;
  localparam int INNER_W  = 10;
  localparam int CNT_W    = 5;
  localparam int ACC_SLOTS = 16;
  localparam int ACC_W    = $clog2(ACC_SLOTS);

  localparam int DEF_MAX_OUT_COLUMNS = 16;
  localparam int DEF_MAX_INNER       = 1024;

  localparam logic [CNT_W-1:0] COLS_RESET = CNT_W'(16);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_NZ    = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             mul_en;
    logic [ACC_W-1:0] mul_k;
    logic             clear;
    logic [ACC_W-1:0] rd_idx;
  } mac_ctl_t;

endpackage

// ===== rtl/csrdt_dense_mem.sv =====
// ----------------------------------------------------------------------------
// csrdt_dense_mem
// Dense matrix store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module csrdt_dense_mem
  import csrdt_pkg::*;
#(
  parameter int DEPTH = 16384
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [VAL_W-1:0]           wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [VAL_W-1:0]           rd_data
);

  logic [VAL_W-1:0] mem [0:DEPTH-1];
  logic [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/csrdt_mac.sv =====
// ----------------------------------------------------------------------------
// csrdt_mac
// Shared multiplier with registered product, saturating accumulate into a
// bank of per-column accumulators.
// ----------------------------------------------------------------------------
module csrdt_mac
  import csrdt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] dense_word,
  input  logic signed [VAL_W-1:0] sparse_val,
  output logic signed [SUM_W-1:0] rd_sum,
  output logic                    busy
);

  logic signed [SUM_W-1:0] prod_r;
  logic                    prod_v_r;
  logic [ACC_W-1:0]        prod_k_r;
  logic signed [SUM_W-1:0] acc_r [ACC_SLOTS];
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r   <= SUM_W'(dense_word * sparse_val);
      prod_k_r <= ctl.mul_k;
    end
  end

  always_comb begin
    sum_wide = {acc_r[prod_k_r][SUM_W-1], acc_r[prod_k_r]} + {prod_r[SUM_W-1], prod_r};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < ACC_SLOTS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (prod_v_r) begin
      acc_r[prod_k_r] <= sum_sat;
    end
  end

  assign rd_sum = acc_r[ctl.rd_idx];
  assign busy   = prod_v_r;

endmodule

// ===== rtl/csr_times_dense_transpose.sv =====
// ----------------------------------------------------------------------------
// csr_times_dense_transpose
// Sparse CSR row stream times transposed dense matrix, Q16.16 in, Q32.32 out.
// ----------------------------------------------------------------------------
// Load items write one dense word each. A sparse nonzero walks the N
// active result columns through one shared multiplier: one dense-store read
// per cycle, then a product stage and a saturating accumulate; the next item
// is taken once the last accumulate is done (N = active columns, 1..16). A
// close item emits N results, one per cycle when out_ready stays high, then
// clears the accumulators; a new item is taken after the last result is
// loaded into the output register. in_ready is low while an item is in work.
// ----------------------------------------------------------------------------
module csr_times_dense_transpose
  import csrdt_pkg::*;
#(
  parameter int MAX_OUT_COLUMNS = DEF_MAX_OUT_COLUMNS,
  parameter int MAX_INNER       = DEF_MAX_INNER
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CNT_W-1:0]        cfg_out_columns,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_op,
  input  logic [DROW_W-1:0]       in_dense_row,
  input  logic [INNER_W-1:0]      in_inner_index,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ROW_W-1:0]        out_row,
  output logic [ACC_W-1:0]        out_column,
  output logic signed [SUM_W-1:0] out_value,
  output logic                    out_last_of_row
);

  localparam int COL_LIMIT  = (MAX_OUT_COLUMNS < ACC_SLOTS) ? MAX_OUT_COLUMNS : ACC_SLOTS;
  localparam int INNER_USED = (MAX_INNER < (1 << INNER_W)) ? MAX_INNER : (1 << INNER_W);
  localparam int COL_W      = $clog2(INNER_USED);
  localparam int DEPTH      = COL_LIMIT << COL_W;
  localparam int ADDR_W     = $clog2(DEPTH);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cols_r;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [CNT_W-1:0]        n_cfg;
  logic [ACC_W-1:0]        k_r, k_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [ROW_W-1:0]        row_cnt_r, row_cnt_nxt;
  logic                    rd_v_r;
  logic [ACC_W-1:0]        rd_k_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]        out_row_r, out_row_nxt;
  logic [ACC_W-1:0]        out_col_r, out_col_nxt;
  logic signed [SUM_W-1:0] out_val_r, out_val_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_xfer;
  logic                    k_last;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [VAL_W-1:0]        rd_data;
  logic signed [SUM_W-1:0] rd_sum;
  logic                    mac_busy;
  mac_ctl_t                mac_ctl;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign k_last    = ({1'b0, k_r} == (n_r - CNT_W'(1)));

  always_comb begin
    n_cfg = (cols_r == '0) ? CNT_W'(1) : cols_r;
    if (n_cfg > CNT_W'(COL_LIMIT)) begin
      n_cfg = CNT_W'(COL_LIMIT);
    end
  end

  assign wr_en   = in_xfer && (in_op == OP_LOAD)
                   && (32'(in_dense_row) < 32'(COL_LIMIT))
                   && (32'(in_inner_index) < 32'(INNER_USED));
  assign wr_addr = ADDR_W'({in_dense_row, in_inner_index[COL_W-1:0]});
  assign rd_addr = ADDR_W'({k_r, col_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cols_r      <= COLS_RESET;
      n_r         <= CNT_W'(1);
      k_r         <= '0;
      row_cnt_r   <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      row_cnt_r   <= row_cnt_nxt;
      rd_v_r      <= rd_en;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cols_r <= cfg_out_columns;
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    val_r      <= val_nxt;
    rd_k_r     <= k_r;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    col_nxt        = col_r;
    val_nxt        = val_r;
    row_cnt_nxt    = row_cnt_r;
    rd_en          = 1'b0;
    mac_ctl.mul_en = rd_v_r;
    mac_ctl.mul_k  = rd_k_r;
    mac_ctl.rd_idx = k_r;
    mac_ctl.clear  = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_val_nxt    = out_val_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          n_nxt = n_cfg;
          k_nxt = '0;
          if (in_op == OP_NZ && (32'(in_inner_index) < 32'(INNER_USED))) begin
            col_nxt   = in_inner_index[COL_W-1:0];
            val_nxt   = in_value;
            state_nxt = ST_MAC;
          end else if (in_op == OP_CLOSE) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_MAC: begin
        rd_en = 1'b1;
        if (k_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + ACC_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !mac_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = row_cnt_r;
          out_col_nxt   = k_r;
          out_val_nxt   = rd_sum;
          out_last_nxt  = k_last;
          if (k_last) begin
            mac_ctl.clear = 1'b1;
            row_cnt_nxt   = row_cnt_r + ROW_W'(1);
            state_nxt     = ST_IDLE;
          end else begin
            k_nxt = k_r + ACC_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  csrdt_dense_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  csrdt_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mac_ctl),
    .dense_word (rd_data),
    .sparse_val (val_r),
    .rd_sum     (rd_sum),
    .busy       (mac_busy)
  );

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_column      = out_col_r;
  assign out_value       = out_val_r;
  assign out_last_of_row = out_last_r;

  // accumulate pipeline must be empty whenever a new item may enter
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!rd_v_r && !mac_busy))
    else $error("item accepted with accumulate in flight");

  a_close_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_CLOSE) |=> (state_r == ST_EMIT))
    else $error("close transfer did not start emission");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC || state_r == ST_EMIT) |-> ({1'b0, k_r} < n_r))
    else $error("column counter beyond active columns");

  a_row_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(row_cnt_r) |-> (out_valid_r && out_last_r))
    else $error("row counter moved without last result");

endmodule

// ===== dv/csr_times_dense_transpose_tb.sv =====
// ----------------------------------------------------------------------------
// csr_times_dense_transpose_tb
// Self-checking bench for the sparse-row times dense-transpose engine.
// Loads dense words, streams sparse rows and closes them under several column
// counts. A bit-accurate predictor follows every accepted item and checks each
// result transfer in order. Sender gaps and receiver stalls are random.
// ----------------------------------------------------------------------------
module csr_times_dense_transpose_tb;
  import csrdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int N_PHASES = 6;
  localparam logic [CNT_W-1:0] PHASE_COLS [N_PHASES] = '{
    5'd31, 5'd1, 5'd16, 5'd7, 5'd17, 5'd12
  };

  typedef struct packed {
    logic [1:0]         op;
    logic [DROW_W-1:0]  drow;
    logic [INNER_W-1:0] inner;
    logic [VAL_W-1:0]   value;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ACC_W-1:0] col;
    logic [SUM_W-1:0] value;
    logic             last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_out_columns = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = '0;
  logic [DROW_W-1:0] in_dense_row = '0;
  logic [INNER_W-1:0] in_inner_index = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ROW_W-1:0] out_row;
  logic [ACC_W-1:0] out_column;
  logic signed [SUM_W-1:0] out_value;
  logic out_last_of_row;

  // predictor state
  logic [VAL_W-1:0] y_words [DEF_MAX_OUT_COLUMNS][DEF_MAX_INNER];
  logic [SUM_W-1:0] col_sums [ACC_SLOTS];
  logic [ROW_W-1:0] rows_closed = '0;
  logic [CNT_W-1:0] cols_reg = COLS_RESET;
  result_t due_results [$];

  // stimulus state
  item_t item_fifo [$];
  item_t cur_item = '0;
  bit loaded [DEF_MAX_OUT_COLUMNS][DEF_MAX_INNER];
  logic [INNER_W-1:0] touched [$];
  logic [INNER_W-1:0] last_fill = '0;
  int gen_cols = 16;
  int stim_items = 0;
  int tx_wait = 0;
  int tx_run = 0;
  int rx_stall = 0;
  int rx_run = 0;
  int results_seen = 0;
  int errors = 0;

  csr_times_dense_transpose dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_out_columns (cfg_out_columns),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_dense_row    (in_dense_row),
    .in_inner_index  (in_inner_index),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row         (out_row),
    .out_column      (out_column),
    .out_value       (out_value),
    .out_last_of_row (out_last_of_row)
  );

  always #1 clk = ~clk;

  function automatic int active_cols(logic [CNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > DEF_MAX_OUT_COLUMNS) return DEF_MAX_OUT_COLUMNS;
    return int'(c);
  endfunction

  function automatic void step_product(item_t it);
    int n;
    longint prod;
    logic signed [SUM_W:0] s;
    n = active_cols(cols_reg);
    case (it.op)
      OP_LOAD: y_words[it.drow][it.inner] = it.value;
      OP_NZ: begin
        for (int k = 0; k < n; k++) begin
          prod = longint'(signed'(it.value)) * longint'(signed'(y_words[k][it.inner]));
          s = longint'(col_sums[k]) + prod;
          if (s[SUM_W] != s[SUM_W-1]) begin
            col_sums[k] = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
          end else begin
            col_sums[k] = s[SUM_W-1:0];
          end
        end
      end
      OP_CLOSE: begin
        for (int k = 0; k < n; k++) begin
          due_results.push_back('{row: rows_closed, col: ACC_W'(k), value: col_sums[k],
                                  last: (k == n - 1)});
        end
        for (int k = 0; k < ACC_SLOTS; k++) col_sums[k] = '0;
        rows_closed = rows_closed + 1;
      end
      default: ;
    endcase
  endfunction

  // mostly short waits, some long ones, occasional bursts with none
  function automatic int draw_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      run = $urandom_range(8, 48);
      return 0;
    end
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 18);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return VAL_W'($urandom_range(0, 131071)) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit col_ready(logic [INNER_W-1:0] i, int n);
    for (int k = 0; k < n; k++) if (!loaded[k][i]) return 1'b0;
    return 1'b1;
  endfunction

  // only inner indices whose dense words are loaded for every active row
  function automatic logic [INNER_W-1:0] pick_inner(int n);
    logic [INNER_W-1:0] i;
    repeat (8) begin
      i = touched[$urandom_range(0, touched.size() - 1)];
      if (col_ready(i, n)) return i;
    end
    return last_fill;
  endfunction

  task automatic queue_item(logic [1:0] op, logic [DROW_W-1:0] drow,
                            logic [INNER_W-1:0] inner, logic [VAL_W-1:0] value);
    item_fifo.push_back('{op: op, drow: drow, inner: inner, value: value});
    if (op != OP_SPARE) stim_items++;
    if (op == OP_LOAD) loaded[drow][inner] = 1'b1;
  endtask

  task automatic fill_column(logic [INNER_W-1:0] i, int n);
    for (int k = 0; k < n; k++) queue_item(OP_LOAD, DROW_W'(k), i, rand_value());
    touched.push_back(i);
    last_fill = i;
  endtask

  task automatic write_cols(logic [CNT_W-1:0] c);
    @(posedge clk);
    cfg_out_columns <= c;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cols_reg = c;
    gen_cols = active_cols(c);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (item_fifo.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin : tx_side
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) step_product(cur_item);
      if (tx_wait != 0) begin
        tx_wait <= tx_wait - 1;
        in_valid <= 1'b0;
      end else if (item_fifo.size() != 0) begin
        nxt = item_fifo.pop_front();
        cur_item <= nxt;
        in_op <= nxt.op;
        in_dense_row <= nxt.drow;
        in_inner_index <= nxt.inner;
        in_value <= nxt.value;
        in_valid <= 1'b1;
        tx_wait <= draw_wait(tx_run);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : rx_side
    result_t want;
    int w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transfer: row %0d col %0d value %h last %0b",
                     out_row, out_column, out_value, out_last_of_row);
        end else begin
          want = due_results.pop_front();
          if (want.row !== out_row || want.col !== out_column ||
              want.value !== out_value || want.last !== out_last_of_row) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp row %0d col %0d value %h last %0b, got row %0d col %0d value %h last %0b",
                       want.row, want.col, want.value, want.last,
                       out_row, out_column, out_value, out_last_of_row);
          end
        end
        w = draw_wait(rx_run);
        out_ready <= (w == 0);
        rx_stall <= w;
      end else if (rx_stall != 0) begin
        rx_stall <= rx_stall - 1;
        out_ready <= (rx_stall == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int quota;
    int r;
    int n;
    for (int k = 0; k < ACC_SLOTS; k++) col_sums[k] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero count acts as one column; saturation both ways and recovery
    write_cols(5'd0);
    queue_item(OP_CLOSE, '0, '0, '0);
    queue_item(OP_SPARE, '1, '1, '1);
    queue_item(OP_LOAD, 4'd0, 10'd0, 32'h7FFF_FFFF);
    queue_item(OP_LOAD, 4'd0, 10'd1023, 32'h8000_0000);
    queue_item(OP_LOAD, 4'd15, 10'd1023, $urandom);
    queue_item(OP_LOAD, 4'd15, 10'd0, 32'h0000_0001);
    touched.push_back(10'd0);
    touched.push_back(10'd1023);
    repeat (3) queue_item(OP_NZ, '1, 10'd0, 32'h7FFF_FFFF);
    queue_item(OP_NZ, '0, 10'd1023, 32'h8000_0000);
    queue_item(OP_NZ, '0, 10'd1023, 32'h7FFF_FFFF);
    queue_item(OP_CLOSE, '1, '1, '1);
    repeat (3) queue_item(OP_NZ, '0, 10'd0, 32'h8000_0000);
    queue_item(OP_NZ, '0, 10'd1023, 32'h8000_0000);
    queue_item(OP_CLOSE, '0, '0, '0);
    queue_item(OP_CLOSE, '0, '0, '0);
    wait_idle();

    // rows may stay open across a count change
    for (int p = 0; p < N_PHASES; p++) begin
      write_cols(PHASE_COLS[p]);
      n = gen_cols;
      quota = stim_items + 76;
      repeat ($urandom_range(1, 2)) fill_column(INNER_W'($urandom), n);
      while (stim_items < quota) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          queue_item(OP_SPARE, DROW_W'($urandom), INNER_W'($urandom), $urandom);
        end else if (r < 13) begin
          queue_item(OP_LOAD, DROW_W'($urandom), touched[0], rand_value());
          touched[0] = INNER_W'($urandom);
          touched.push_back(touched[0]);
          touched[0] = 10'd0;
        end else if (r < 19) begin
          queue_item(OP_LOAD, DROW_W'($urandom),
                     touched[$urandom_range(0, touched.size() - 1)], rand_value());
        end else if (r < 21) begin
          fill_column(INNER_W'($urandom), n);
        end else if (r < 35) begin
          queue_item(OP_CLOSE, DROW_W'($urandom), INNER_W'($urandom), $urandom);
        end else begin
          queue_item(OP_NZ, DROW_W'($urandom), pick_inner(n), rand_value());
        end
      end
      wait_idle();
    end

    errors += due_results.size();
    $display("covered %0d items over %0d column counts, %0d rows closed",
             stim_items, N_PHASES + 1, rows_closed);
    $display("%0d result transfers checked", results_seen);
    if (errors == 0) begin
      $display("csr_times_dense_transpose_tb: clean");
    end else begin
      $display("csr_times_dense_transpose_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("csr_times_dense_transpose_tb: errors");
    $finish;
  end

endmodule
